>>> hw/rtl/pmcr_pkg.sv
`timescale 1ns / 1ps
package pmcr_pkg;
	localparam int COORD_WIDTH  = 24;
	localparam int COUNT_WIDTH  = 16;
	localparam int THR_WIDTH    = 40;
	localparam int SUM_WIDTH    = 48;
	localparam int RADIUS_WIDTH = 32;
	localparam int STATUS_WIDTH = 2;

	// difference of two points, and its magnitude, scaled down by 8 when one axis is at least 2**30
	localparam int DIFF_W    = COORD_WIDTH + 1;
	localparam int BIG_SHIFT = 30;
	localparam int BIG_SCALE = 3;
	localparam int MAG_W     = (DIFF_W > BIG_SHIFT) ? BIG_SHIFT : DIFF_W;

	// unit tangent, signed Q1.16
	localparam int TAN_W    = 18;
	localparam int TAN_FRAC = 16;
	localparam int DT_W     = TAN_W + 1;

	localparam int MUL_W = (MAG_W > TAN_W) ? MAG_W : TAN_W;
	localparam int SQ_W  = 2 * MUL_W + 2;
	localparam int DEN_W = (SQ_W - 2 > SUM_WIDTH) ? SQ_W - 2 : SUM_WIDTH;

	// shared divide / square root unit
	localparam int ACC_W      = 64;
	localparam int STEP_W     = 7;
	localparam int LEN_W      = 32;
	localparam int TERM_W     = 31;
	localparam int NORM_TOP   = 60;
	localparam int SQRT_STEPS = ACC_W / 2;
	localparam int TDIV_STEPS = TAN_W;
	localparam int TERM_SHIFT = 24;
	localparam int TERM_STEPS = 60;
	localparam int RAD_SHIFT  = 28;
	localparam int RAD_STEPS  = COUNT_WIDTH + RAD_SHIFT;

	localparam logic [TAN_W-1:0]     UNIT_Q16  = TAN_W'(65536);
	localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(6554);

	localparam logic [STATUS_WIDTH-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_WIDTH-1:0] STATUS_FEW  = 2'd1;
	localparam logic [STATUS_WIDTH-1:0] STATUS_ZERO = 2'd2;

	localparam logic OP_DIV  = 1'b0;
	localparam logic OP_SQRT = 1'b1;

	typedef struct packed {
		logic              start;
		logic              op;
		logic [STEP_W-1:0] steps;
	} unit_req_t;
endpackage

>>> hw/rtl/pmcr_if.sv
`timescale 1ns / 1ps
interface pmcr_pt_if;
	logic valid;
	logic ready;
	logic signed [pmcr_pkg::COORD_WIDTH-1:0] coord_x;
	logic signed [pmcr_pkg::COORD_WIDTH-1:0] coord_y;
	logic signed [pmcr_pkg::COORD_WIDTH-1:0] coord_z;
	logic last_point;

	modport source(output valid, coord_x, coord_y, coord_z, last_point, input ready);
	modport sink(input valid, coord_x, coord_y, coord_z, last_point, output ready);
endinterface

interface pmcr_res_if;
	logic valid;
	logic ready;
	logic [pmcr_pkg::RADIUS_WIDTH-1:0] mean_radius;
	logic [pmcr_pkg::STATUS_WIDTH-1:0] status;

	modport source(output valid, mean_radius, status, input ready);
	modport sink(input valid, mean_radius, status, output ready);
endinterface

>>> hw/rtl/polyline_mean_curvature_radius.sv
`timescale 1ns / 1ps
// channel  dir  word                                        handshake
// pt       in   coord_x/y/z (Q15.8 signed), last_point      valid/ready
// res      out  mean_radius (Q24.8), status                 valid/ready
// cfg      in   cfg_wdata -> min_quarter_chord_sq           cfg_we, no stall
//
// One point at a time; pt.ready is high only while the sequencer is idle.
// First point of a line: only the stored points are updated. Zero-length segment: tangent zero,
// and from the third point the chord test still runs. Other points: normalise, a square root
// for the length and three tangent divides on the shared unit; from the third point the chord
// test, then a term divide and square root when it passes. Last point: a status word, through
// the 44-step radius divide when there are over two terms and a nonzero sum. arst_n clears all
// state, threshold=6554. A finished word waits in the res register; the next one waits for it.
module polyline_mean_curvature_radius (
	input  logic                              clk,
	input  logic                              arst_n,
	pmcr_pt_if.sink                           pt,
	pmcr_res_if.source                        res,
	input  logic                              cfg_we,
	input  logic [pmcr_pkg::THR_WIDTH-1:0]    cfg_wdata
);
	localparam int CW = pmcr_pkg::COORD_WIDTH;
	localparam int DW = pmcr_pkg::DIFF_W;
	localparam int TW = pmcr_pkg::TAN_W;
	localparam int MW = pmcr_pkg::MUL_W;

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_MAG       = 4'd1;
	localparam logic [3:0] ST_SQ        = 4'd2;
	localparam logic [3:0] ST_POST      = 4'd3;
	localparam logic [3:0] ST_NORM      = 4'd4;
	localparam logic [3:0] ST_LEN       = 4'd5;
	localparam logic [3:0] ST_TDIV      = 4'd6;
	localparam logic [3:0] ST_TERM_DIV  = 4'd7;
	localparam logic [3:0] ST_TERM_SQRT = 4'd8;
	localparam logic [3:0] ST_ACC       = 4'd9;
	localparam logic [3:0] ST_UPD       = 4'd10;
	localparam logic [3:0] ST_FIN       = 4'd11;
	localparam logic [3:0] ST_RAD_DIV   = 4'd12;
	localparam logic [3:0] ST_OUT       = 4'd13;

	// which vector the magnitude / square-sum pass works on
	localparam logic [1:0] PH_SEG = 2'd0;
	localparam logic [1:0] PH_CH  = 2'd1;
	localparam logic [1:0] PH_DT  = 2'd2;

	logic [3:0] state_q;
	logic [1:0] phase_q;
	logic [1:0] idx_q;
	logic       issued_q;

	logic signed [CW-1:0] px_q, py_q, pz_q;
	logic                 last_q;
	logic signed [CW-1:0] prior_x_q [2];
	logic signed [CW-1:0] prior_y_q [2];
	logic signed [CW-1:0] prior_z_q [2];
	logic signed [TW-1:0] tan_x_q, tan_y_q, tan_z_q;
	logic signed [TW-1:0] t2_q [3];
	logic [pmcr_pkg::SUM_WIDTH-1:0]   sum_q;
	logic [pmcr_pkg::COUNT_WIDTH-1:0] cnt_q;
	logic [1:0]                       pts_q;
	logic [pmcr_pkg::THR_WIDTH-1:0]   thr_q;

	logic [MW-1:0]                  mv_q [3];
	logic                           sgn_q [3];
	logic                           chord_big_q;
	logic [pmcr_pkg::DEN_W-1:0]     qc_q;
	logic [2*MW-1:0]                prod_q;
	logic [pmcr_pkg::SQ_W-1:0]      sq_acc_q;
	logic [pmcr_pkg::ACC_W-1:0]     x_q;
	logic [5:0]                     s_q;
	logic [pmcr_pkg::LEN_W-1:0]     len_q;
	logic [pmcr_pkg::TERM_W-1:0]    term_q;
	logic [pmcr_pkg::RADIUS_WIDTH-1:0] rad_q;
	logic [pmcr_pkg::STATUS_WIDTH-1:0] stat_q;

	logic                              res_valid_q;
	logic [pmcr_pkg::RADIUS_WIDTH-1:0] res_rad_q;
	logic [pmcr_pkg::STATUS_WIDTH-1:0] res_stat_q;

	// combinational
	logic signed [CW-1:0] cur [3];
	logic signed [CW-1:0] ref_c [3];
	logic signed [TW-1:0] tan_c [3];
	logic [DW-1:0]        dif [3];
	logic [DW-1:0]        mag [3];
	logic [MW-1:0]        red [3];
	logic [pmcr_pkg::DT_W-1:0] dtd [3];
	logic [TW-1:0]        dtm [3];
	logic                 big;
	logic [MW-1:0]        mv_sel;
	logic                 sgn_sel;
	logic [TW-1:0]        qv;
	logic [pmcr_pkg::DEN_W-1:0] qc;
	logic                 pass;
	logic [pmcr_pkg::SUM_WIDTH:0] sum_ext;

	pmcr_pkg::unit_req_t         req;
	logic [pmcr_pkg::ACC_W-1:0]  unum;
	logic [pmcr_pkg::DEN_W-1:0]  uden;
	logic                        u_done;
	logic [pmcr_pkg::ACC_W-1:0]  u_res;

	pmcr_divsqrt u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.num    (unum),
		.den    (uden),
		.done   (u_done),
		.res    (u_res)
	);

	// differences and magnitudes for the three axes
	always_comb begin
		cur[0] = px_q;
		cur[1] = py_q;
		cur[2] = pz_q;
		tan_c[0] = tan_x_q;
		tan_c[1] = tan_y_q;
		tan_c[2] = tan_z_q;
		if (phase_q == PH_CH) begin
			ref_c[0] = prior_x_q[1];
			ref_c[1] = prior_y_q[1];
			ref_c[2] = prior_z_q[1];
		end else begin
			ref_c[0] = prior_x_q[0];
			ref_c[1] = prior_y_q[0];
			ref_c[2] = prior_z_q[0];
		end
		big = 1'b0;
		for (int i = 0; i < 3; i++) begin
			dif[i] = {cur[i][CW-1], cur[i]} - {ref_c[i][CW-1], ref_c[i]};
			mag[i] = dif[i][DW-1] ? (-dif[i]) : dif[i];
			if ((mag[i] >> pmcr_pkg::BIG_SHIFT) != '0) big = 1'b1;
			dtd[i] = {t2_q[i][TW-1], t2_q[i]} - {tan_c[i][TW-1], tan_c[i]};
			dtm[i] = dtd[i][pmcr_pkg::DT_W-1] ? TW'(-dtd[i]) : TW'(dtd[i]);
		end
		for (int i = 0; i < 3; i++) begin
			red[i] = big ? MW'(mag[i] >> pmcr_pkg::BIG_SCALE) : MW'(mag[i]);
		end
	end

	always_comb begin
		case (idx_q)
			2'd0: begin mv_sel = mv_q[0]; sgn_sel = sgn_q[0]; end
			2'd1: begin mv_sel = mv_q[1]; sgn_sel = sgn_q[1]; end
			2'd2: begin mv_sel = mv_q[2]; sgn_sel = sgn_q[2]; end
			default: begin mv_sel = '0; sgn_sel = 1'b0; end
		endcase
		// tangent component, capped at one
		qv = (u_res[TW-1:0] > pmcr_pkg::UNIT_Q16) ? pmcr_pkg::UNIT_Q16 : u_res[TW-1:0];
		qc = pmcr_pkg::DEN_W'(sq_acc_q >> 2);
		pass = (qc != '0) &&
			(chord_big_q || (qc >= pmcr_pkg::DEN_W'(thr_q)));
		sum_ext = {1'b0, sum_q} + (pmcr_pkg::SUM_WIDTH + 1)'(term_q);
	end

	// operands for the shared unit
	always_comb begin
		req.start = 1'b0;
		req.op    = pmcr_pkg::OP_DIV;
		req.steps = '0;
		unum      = '0;
		uden      = '0;
		case (state_q)
			ST_LEN: begin
				req.start = !issued_q;
				req.op    = pmcr_pkg::OP_SQRT;
				req.steps = pmcr_pkg::STEP_W'(pmcr_pkg::SQRT_STEPS);
				unum      = x_q;
			end
			ST_TDIV: begin
				req.start = !issued_q;
				req.steps = pmcr_pkg::STEP_W'(pmcr_pkg::TDIV_STEPS);
				unum      = (pmcr_pkg::ACC_W'(mv_sel) << (pmcr_pkg::TAN_FRAC + s_q[5:1]))
					+ pmcr_pkg::ACC_W'(len_q >> 1);
				uden      = pmcr_pkg::DEN_W'(len_q);
			end
			ST_TERM_DIV: begin
				req.start = !issued_q;
				req.steps = pmcr_pkg::STEP_W'(pmcr_pkg::TERM_STEPS);
				unum      = (x_q << pmcr_pkg::TERM_SHIFT)
					>> (chord_big_q ? 2 * pmcr_pkg::BIG_SCALE : 0);
				uden      = qc_q;
			end
			ST_TERM_SQRT: begin
				req.start = !issued_q;
				req.op    = pmcr_pkg::OP_SQRT;
				req.steps = pmcr_pkg::STEP_W'(pmcr_pkg::SQRT_STEPS);
				unum      = x_q;
			end
			ST_RAD_DIV: begin
				req.start = !issued_q;
				req.steps = pmcr_pkg::STEP_W'(pmcr_pkg::RAD_STEPS);
				unum      = pmcr_pkg::ACC_W'(cnt_q) << pmcr_pkg::RAD_SHIFT;
				uden      = pmcr_pkg::DEN_W'(sum_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_SEG;
			idx_q       <= '0;
			issued_q    <= 1'b0;
			px_q        <= '0;
			py_q        <= '0;
			pz_q        <= '0;
			last_q      <= 1'b0;
			prior_x_q   <= '{default: '0};
			prior_y_q   <= '{default: '0};
			prior_z_q   <= '{default: '0};
			tan_x_q     <= '0;
			tan_y_q     <= '0;
			tan_z_q     <= '0;
			t2_q        <= '{default: '0};
			sum_q       <= '0;
			cnt_q       <= '0;
			pts_q       <= '0;
			thr_q       <= pmcr_pkg::THR_RESET;
			mv_q        <= '{default: '0};
			sgn_q       <= '{default: 1'b0};
			chord_big_q <= 1'b0;
			qc_q        <= '0;
			prod_q      <= '0;
			sq_acc_q    <= '0;
			x_q         <= '0;
			s_q         <= '0;
			len_q       <= '0;
			term_q      <= '0;
			rad_q       <= '0;
			stat_q      <= pmcr_pkg::STATUS_OK;
			res_valid_q <= 1'b0;
			res_rad_q   <= '0;
			res_stat_q  <= pmcr_pkg::STATUS_OK;
		end else begin
			if (cfg_we) thr_q <= cfg_wdata;
			if (req.start) issued_q <= 1'b1;
			if (u_done) issued_q <= 1'b0;
			// in ST_OUT the word register is handled below
			if (res_valid_q && res.ready && state_q != ST_OUT) res_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (pt.valid) begin
						px_q   <= pt.coord_x;
						py_q   <= pt.coord_y;
						pz_q   <= pt.coord_z;
						last_q <= pt.last_point;
						phase_q <= PH_SEG;
						state_q <= (pts_q == 2'd0) ? ST_UPD : ST_MAG;
					end
				end
				ST_MAG: begin
					for (int i = 0; i < 3; i++) begin
						mv_q[i] <= (phase_q == PH_DT) ? MW'(dtm[i]) : red[i];
						if (phase_q == PH_SEG) sgn_q[i] <= dif[i][DW-1];
					end
					if (phase_q == PH_CH) chord_big_q <= big;
					prod_q   <= '0;
					sq_acc_q <= '0;
					idx_q    <= '0;
					state_q  <= ST_SQ;
				end
				ST_SQ: begin
					// square into prod_q, then accumulate the registered product
					prod_q   <= mv_sel * mv_sel;
					sq_acc_q <= sq_acc_q + pmcr_pkg::SQ_W'(prod_q);
					idx_q    <= idx_q + 1'b1;
					if (idx_q == 2'd3) state_q <= ST_POST;
				end
				ST_POST: begin
					case (phase_q)
						PH_SEG: begin
							if (sq_acc_q == '0) begin
								t2_q <= '{default: '0};
								phase_q <= PH_CH;
								state_q <= (pts_q == 2'd2) ? ST_MAG : ST_UPD;
							end else begin
								x_q     <= pmcr_pkg::ACC_W'(sq_acc_q);
								s_q     <= '0;
								state_q <= ST_NORM;
							end
						end
						PH_CH: begin
							qc_q <= qc;
							if (pass) begin
								phase_q <= PH_DT;
								state_q <= ST_MAG;
							end else begin
								state_q <= ST_UPD;
							end
						end
						PH_DT: begin
							x_q     <= pmcr_pkg::ACC_W'(sq_acc_q);
							state_q <= ST_TERM_DIV;
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_NORM: begin
					// two bits a cycle until the top nibble is nonzero or the shift reaches NORM_TOP
					if (s_q <= 6'(pmcr_pkg::NORM_TOP - 2) &&
						x_q[pmcr_pkg::ACC_W-1 -: (pmcr_pkg::ACC_W - pmcr_pkg::NORM_TOP)] == '0) begin
						x_q <= x_q << 2;
						s_q <= s_q + 6'd2;
					end else begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					if (u_done) begin
						len_q   <= u_res[pmcr_pkg::LEN_W-1:0];
						idx_q   <= '0;
						state_q <= ST_TDIV;
					end
				end
				ST_TDIV: begin
					if (u_done) begin
						t2_q[idx_q] <= sgn_sel ? TW'(-qv) : qv;
						if (idx_q == 2'd2) begin
							phase_q <= PH_CH;
							state_q <= (pts_q == 2'd2) ? ST_MAG : ST_UPD;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_TERM_DIV: begin
					if (u_done) begin
						x_q     <= u_res;
						state_q <= ST_TERM_SQRT;
					end
				end
				ST_TERM_SQRT: begin
					if (u_done) begin
						term_q  <= u_res[pmcr_pkg::TERM_W-1:0];
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					sum_q <= sum_ext[pmcr_pkg::SUM_WIDTH] ? '1
						: sum_ext[pmcr_pkg::SUM_WIDTH-1:0];
					if (!(&cnt_q)) cnt_q <= cnt_q + 1'b1;
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (pts_q != 2'd0) begin
						tan_x_q <= t2_q[0];
						tan_y_q <= t2_q[1];
						tan_z_q <= t2_q[2];
					end
					prior_x_q[1] <= prior_x_q[0];
					prior_y_q[1] <= prior_y_q[0];
					prior_z_q[1] <= prior_z_q[0];
					prior_x_q[0] <= px_q;
					prior_y_q[0] <= py_q;
					prior_z_q[0] <= pz_q;
					if (pts_q != 2'd2) pts_q <= pts_q + 1'b1;
					state_q <= last_q ? ST_FIN : ST_IDLE;
				end
				ST_FIN: begin
					if (cnt_q <= pmcr_pkg::COUNT_WIDTH'(2)) begin
						rad_q   <= '0;
						stat_q  <= pmcr_pkg::STATUS_FEW;
						state_q <= ST_OUT;
					end else if (sum_q == '0) begin
						rad_q   <= '1;
						stat_q  <= pmcr_pkg::STATUS_ZERO;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_RAD_DIV;
					end
				end
				ST_RAD_DIV: begin
					if (u_done) begin
						rad_q <= ((u_res >> pmcr_pkg::RADIUS_WIDTH) != '0) ? '1
							: u_res[pmcr_pkg::RADIUS_WIDTH-1:0];
						stat_q  <= pmcr_pkg::STATUS_OK;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!res_valid_q || res.ready) begin
						res_valid_q <= 1'b1;
						res_rad_q   <= rad_q;
						res_stat_q  <= stat_q;
						// polyline done: start over
						prior_x_q <= '{default: '0};
						prior_y_q <= '{default: '0};
						prior_z_q <= '{default: '0};
						tan_x_q   <= '0;
						tan_y_q   <= '0;
						tan_z_q   <= '0;
						sum_q     <= '0;
						cnt_q     <= '0;
						pts_q     <= '0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign pt.ready        = (state_q == ST_IDLE);
	assign res.valid       = res_valid_q;
	assign res.mean_radius = res_rad_q;
	assign res.status      = res_stat_q;
endmodule

>>> hw/rtl/pmcr_divsqrt.sv
`timescale 1ns / 1ps
// One bit per cycle restoring divider / two bits per cycle square root.
module pmcr_divsqrt (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pmcr_pkg::unit_req_t                req,
	input  logic [pmcr_pkg::ACC_W-1:0]         num,
	input  logic [pmcr_pkg::DEN_W-1:0]         den,
	output logic                               done,
	output logic [pmcr_pkg::ACC_W-1:0]         res
);
	logic                             busy_q;
	logic                             done_q;
	logic                             op_q;
	logic [pmcr_pkg::STEP_W-1:0]      cnt_q;
	logic [pmcr_pkg::ACC_W-1:0]       acc_q;
	logic [pmcr_pkg::ACC_W-1:0]       res_q;
	logic [pmcr_pkg::DEN_W-1:0]       rem_q;
	logic [pmcr_pkg::DEN_W-1:0]       den_q;
	logic [pmcr_pkg::DEN_W:0]         sh;
	logic [pmcr_pkg::DEN_W:0]         tr;
	logic [pmcr_pkg::DEN_W:0]         dif;
	logic                             ge;

	always_comb begin
		if (op_q == pmcr_pkg::OP_SQRT) begin
			sh = {rem_q[pmcr_pkg::DEN_W-2:0], acc_q[pmcr_pkg::ACC_W-1 -: 2]};
			tr = {res_q[pmcr_pkg::DEN_W-2:0], 2'b01};
		end else begin
			sh = {rem_q, acc_q[pmcr_pkg::ACC_W-1]};
			tr = {1'b0, den_q};
		end
		ge  = (sh >= tr);
		dif = sh - tr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= pmcr_pkg::OP_DIV;
			cnt_q  <= '0;
			acc_q  <= '0;
			res_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= req.steps;
				den_q  <= den;
				res_q  <= '0;
				if (req.op == pmcr_pkg::OP_SQRT) begin
					rem_q <= '0;
					acc_q <= num;
				end else begin
					// upper part is below the divisor: quotient fits in steps bits
					rem_q <= pmcr_pkg::DEN_W'(num >> req.steps);
					acc_q <= num << (pmcr_pkg::STEP_W'(pmcr_pkg::ACC_W) - req.steps);
				end
			end else if (busy_q) begin
				rem_q <= ge ? dif[pmcr_pkg::DEN_W-1:0] : sh[pmcr_pkg::DEN_W-1:0];
				res_q <= {res_q[pmcr_pkg::ACC_W-2:0], ge};
				acc_q <= (op_q == pmcr_pkg::OP_SQRT) ? (acc_q << 2) : (acc_q << 1);
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == pmcr_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;
endmodule

>>> hw/rtl/pmcr_chk.sv
`timescale 1ns / 1ps
module pmcr_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [pmcr_pkg::RADIUS_WIDTH-1:0]   mean_radius,
	input logic [pmcr_pkg::STATUS_WIDTH-1:0]   status
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mean_radius) && $stable(status))
		else $error("result word changed while stalled");

	a_few_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == pmcr_pkg::STATUS_FEW |-> mean_radius == '0)
		else $error("too-few-terms result with nonzero radius");

	a_zero_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == pmcr_pkg::STATUS_ZERO |-> (&mean_radius))
		else $error("zero-sum result not saturated");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while previous point in work");
endmodule

bind polyline_mean_curvature_radius pmcr_chk u_pmcr_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (pt.valid),
	.in_ready    (pt.ready),
	.out_valid   (res.valid),
	.out_ready   (res.ready),
	.mean_radius (res.mean_radius),
	.status      (res.status)
);
